// ===== rtl/scvs_pkg.sv =====
// ----------------------------------------------------------------------------
// scvs_pkg
// Shared sizes, codes and types for the second-chance victim selector.
// ----------------------------------------------------------------------------
package scvs_pkg;

    localparam int POOL_ENTRIES = 64;
    localparam int POOL_COUNT   = 2;
    localparam int FIX_BITS     = 8;
    localparam int SWEEP_FACTOR = 2;

    localparam int TOTAL_ENTRIES = POOL_ENTRIES * POOL_COUNT;
    localparam int IDX_W         = $clog2(POOL_ENTRIES);
    localparam int ADDR_W        = $clog2(TOTAL_ENTRIES);
    localparam int POOL_W        = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int SWEEP_LIMIT   = SWEEP_FACTOR * POOL_ENTRIES;
    localparam int CNT_W         = $clog2(SWEEP_LIMIT);

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    localparam int ENTRY_INDEX_W = 6;
    localparam int FIX_VALUE_W   = 8;
    localparam int VICTIM_W      = 6;

    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ALLOC       = 2'd0,
        STATUS_NO_UNFIXED  = 2'd1,
        STATUS_UPDATE_DONE = 2'd2
    } status_t;

    typedef struct packed {
        logic                key;
        logic [FIX_BITS-1:0] fix;
        logic                dirty;
        logic                refer;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic sweep;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_op_update;
        logic in_pool_ok;
        logic sweep_done;
    } stat_t;

endpackage

// ===== rtl/scvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// scvs_ctrl
// Request sequencing: accept, sweep, hand-off to the result register.
// ----------------------------------------------------------------------------
module scvs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  scvs_pkg::stat_t stat,
    output scvs_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_DONE  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd.accept   = s_tvalid && (state_reg == ST_IDLE);
        cmd.sweep    = (state_reg == ST_SWEEP);
        cmd.out_load = (state_reg == ST_DONE) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) begin
                    if (stat.in_op_update || !stat.in_pool_ok) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                if (stat.sweep_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== rtl/scvs_datapath.sv =====
// ----------------------------------------------------------------------------
// scvs_datapath
// Entry mark memory, clock hands, sweep pipeline and result registers.
// ----------------------------------------------------------------------------
module scvs_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  scvs_pkg::cmd_t                 cmd,
    output scvs_pkg::stat_t                stat,
    input  logic [scvs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [scvs_pkg::S_TUSER_W-1:0] s_tuser,
    output logic [scvs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [scvs_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int IDX_W  = scvs_pkg::IDX_W;
    localparam int ADDR_W = scvs_pkg::ADDR_W;
    localparam int POOL_W = scvs_pkg::POOL_W;
    localparam int CNT_W  = scvs_pkg::CNT_W;

    function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (int'(p) == scvs_pkg::POOL_ENTRIES - 1) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // request fields
    logic                                in_op;
    logic                                in_pool;
    logic [scvs_pkg::ENTRY_INDEX_W-1:0]  in_idx;
    logic                                in_refer;
    logic                                in_dirty;
    logic [scvs_pkg::FIX_VALUE_W-1:0]    in_fix;
    logic                                in_key;
    logic                                in_pool_ok;
    logic                                in_idx_ok;
    logic [ADDR_W-1:0]                   in_base;
    logic [ADDR_W-1:0]                   upd_addr;
    scvs_pkg::entry_t                    upd_word;

    // mark memory and valid bits
    scvs_pkg::entry_t mem [scvs_pkg::TOTAL_ENTRIES];
    logic [scvs_pkg::TOTAL_ENTRIES-1:0] valid_reg;
    scvs_pkg::entry_t mem_q_reg;
    logic             vld_q_reg;

    logic [IDX_W-1:0] hand_reg [scvs_pkg::POOL_COUNT];

    // sweep pipeline
    logic [POOL_W-1:0] pool_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [IDX_W-1:0]  rd_pos_reg;
    logic [IDX_W-1:0]  ev_pos_reg;
    logic              ev_valid_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] ev_addr;

    scvs_pkg::entry_t ev_word;
    logic             ev_active;
    logic             ev_unfixed;
    logic             ev_found;
    logic             ev_clear;
    logic             ev_last;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    scvs_pkg::entry_t  wr_data;
    logic              do_update;
    logic              do_start;

    // pending result
    scvs_pkg::status_t                  res_status_reg;
    logic [scvs_pkg::VICTIM_W-1:0]      res_victim_reg;
    logic                               res_flush_reg;
    logic                               res_unhash_reg;
    logic [scvs_pkg::M_TDATA_W-1:0]     m_tdata_reg;
    logic [scvs_pkg::M_TUSER_W-1:0]     m_tuser_reg;

    assign in_op    = s_tuser[0];
    assign in_pool  = s_tuser[1];
    assign in_idx   = s_tdata[5:0];
    assign in_refer = s_tdata[6];
    assign in_dirty = s_tdata[7];
    assign in_fix   = s_tdata[15:8];
    assign in_key   = s_tdata[16];

    assign in_pool_ok = (int'(in_pool) < scvs_pkg::POOL_COUNT);
    assign in_idx_ok  = (int'(in_idx) < scvs_pkg::POOL_ENTRIES);
    assign in_base    = ADDR_W'(ADDR_W'(in_pool) * ADDR_W'(scvs_pkg::POOL_ENTRIES));
    assign upd_addr   = in_base + ADDR_W'(IDX_W'(in_idx));

    always_comb begin
        upd_word.key   = in_key;
        upd_word.fix   = scvs_pkg::FIX_BITS'(in_fix);
        upd_word.dirty = in_dirty;
        upd_word.refer = in_refer;
    end

    assign do_update = cmd.accept && (in_op == scvs_pkg::OP_UPDATE);
    assign do_start  = cmd.accept && (in_op == scvs_pkg::OP_ALLOC) && in_pool_ok;

    assign stat.in_op_update = (in_op == scvs_pkg::OP_UPDATE);
    assign stat.in_pool_ok   = in_pool_ok;

    assign rd_addr = base_reg + ADDR_W'(rd_pos_reg);
    assign ev_addr = base_reg + ADDR_W'(ev_pos_reg);

    // entries never written read as all-zero marks
    assign ev_word    = vld_q_reg ? mem_q_reg : '0;
    assign ev_active  = cmd.sweep && ev_valid_reg;
    assign ev_unfixed = (ev_word.fix == '0);
    assign ev_found   = ev_active && ev_unfixed && !ev_word.refer;
    assign ev_clear   = ev_active && ev_unfixed && ev_word.refer;
    assign ev_last    = (cnt_reg == CNT_W'(scvs_pkg::SWEEP_LIMIT - 1));
    assign stat.sweep_done = ev_active && (ev_found || ev_last);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ev_addr;
        wr_data = ev_word;
        if (do_update) begin
            wr_en   = in_pool_ok && in_idx_ok;
            wr_addr = upd_addr;
            wr_data = upd_word;
        end else if (ev_found) begin
            wr_en         = 1'b1;
            wr_data       = '0;
            wr_data.refer = 1'b1;
        end else if (ev_clear) begin
            wr_en         = 1'b1;
            wr_data.refer = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
        vld_q_reg <= valid_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < scvs_pkg::POOL_COUNT; p++) begin
                hand_reg[p] <= '0;
            end
        end else if (ev_found) begin
            hand_reg[pool_reg] <= next_pos(ev_pos_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else if (do_start) begin
            ev_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else if (cmd.sweep) begin
            ev_valid_reg <= 1'b1;
            if (ev_active) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_start) begin
            pool_reg   <= POOL_W'(in_pool);
            base_reg   <= in_base;
            rd_pos_reg <= hand_reg[POOL_W'(in_pool)];
        end else if (cmd.sweep) begin
            rd_pos_reg <= next_pos(rd_pos_reg);
            ev_pos_reg <= rd_pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_update) begin
            res_status_reg <= scvs_pkg::STATUS_UPDATE_DONE;
            res_victim_reg <= '0;
            res_flush_reg  <= 1'b0;
            res_unhash_reg <= 1'b0;
        end else if (cmd.accept && !in_pool_ok) begin
            res_status_reg <= scvs_pkg::STATUS_NO_UNFIXED;
            res_victim_reg <= '0;
            res_flush_reg  <= 1'b0;
            res_unhash_reg <= 1'b0;
        end else if (ev_found) begin
            res_status_reg <= scvs_pkg::STATUS_ALLOC;
            res_victim_reg <= scvs_pkg::VICTIM_W'(ev_pos_reg);
            res_flush_reg  <= ev_word.dirty;
            res_unhash_reg <= ev_word.key;
        end else if (ev_active && ev_last) begin
            res_status_reg <= scvs_pkg::STATUS_NO_UNFIXED;
            res_victim_reg <= '0;
            res_flush_reg  <= 1'b0;
            res_unhash_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {res_unhash_reg, res_flush_reg, res_victim_reg};
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

// ===== rtl/second_chance_victim_select.sv =====
// ----------------------------------------------------------------------------
// second_chance_victim_select
// Clock (second-chance) victim selection over two buffer pools.
// ----------------------------------------------------------------------------
// One request at a time. An update request goes from ST_IDLE to ST_DONE,
// where its result is loaded into the output register once that register is
// free; the block then returns to ST_IDLE and can take the next request. An
// allocate request goes through ST_SWEEP before ST_DONE; the sweep visits
// entries until it finds a victim (at most twice the pool size, 128 entries)
// and visits one entry per cycle, bounded by the single registered read port
// of the entry mark memory. An allocate with a pool select beyond the pool
// count is handled like an update. A new request is taken while the previous
// result still waits in the output register; the request after it waits
// until that result has been accepted.
// ----------------------------------------------------------------------------
module second_chance_victim_select (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_index[5:0], refer_value[6], dirty_value[7], fix_value[15:8],
    // key_value[16], zero[23:17]
    input  logic [scvs_pkg::S_TDATA_W-1:0] s_tdata,
    // op[0], pool[1]
    input  logic [scvs_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // victim[5:0], needs_flush[6], needs_unhash[7]
    output logic [scvs_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [scvs_pkg::M_TUSER_W-1:0] m_tuser
);

    scvs_pkg::cmd_t  cmd;
    scvs_pkg::stat_t stat;

    scvs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scvs_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// ===== dv/tb_second_chance_victim_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_second_chance_victim_select
// Self-checking bench for the second-chance victim selector. Requests go in
// on the s_ stream with bursty timing and results leave on the m_ stream
// under changing stall patterns. A scoreboard keeps its own copy of both
// pools and clock hands and checks every result in order.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                               op;
    logic                               pool;
    logic [scvs_pkg::ENTRY_INDEX_W-1:0] idx;
    logic                               refer;
    logic                               dirty;
    logic [scvs_pkg::FIX_VALUE_W-1:0]   fix;
    logic                               key;
} buf_request_t;

typedef struct packed {
    scvs_pkg::status_t             status;
    logic [scvs_pkg::VICTIM_W-1:0] victim;
    logic                          flush;
    logic                          unhash;
} buf_result_t;

class victim_scoreboard;
    bit                          refer_q [scvs_pkg::TOTAL_ENTRIES];
    bit                          dirty_q [scvs_pkg::TOTAL_ENTRIES];
    bit [scvs_pkg::FIX_BITS-1:0] fix_q   [scvs_pkg::TOTAL_ENTRIES];
    bit                          key_q   [scvs_pkg::TOTAL_ENTRIES];
    int                          hand_q  [scvs_pkg::POOL_COUNT];
    buf_result_t                 awaited_results [$];
    int                          failures;

    function void note_request(buf_request_t r);
        buf_result_t res;
        int          base;
        int          pos;
        int          slot;
        bit          found;
        res.status = scvs_pkg::STATUS_UPDATE_DONE;
        res.victim = '0;
        res.flush  = 1'b0;
        res.unhash = 1'b0;
        if (r.op == scvs_pkg::OP_UPDATE) begin
            if (r.pool < scvs_pkg::POOL_COUNT && r.idx < scvs_pkg::POOL_ENTRIES) begin
                slot = int'(r.pool) * scvs_pkg::POOL_ENTRIES + int'(r.idx);
                refer_q[slot] = r.refer;
                dirty_q[slot] = r.dirty;
                fix_q[slot]   = r.fix[scvs_pkg::FIX_BITS-1:0];
                key_q[slot]   = r.key;
            end
        end else if (r.pool >= scvs_pkg::POOL_COUNT) begin
            res.status = scvs_pkg::STATUS_NO_UNFIXED;
        end else begin
            base  = int'(r.pool) * scvs_pkg::POOL_ENTRIES;
            pos   = hand_q[r.pool];
            found = 1'b0;
            // fixed entries are passed over, referenced ones lose their bit
            for (int i = 0; i < scvs_pkg::SWEEP_LIMIT && !found; i++) begin
                slot = base + pos;
                if (fix_q[slot] == 0 && !refer_q[slot]) begin
                    found = 1'b1;
                end else begin
                    if (fix_q[slot] == 0) refer_q[slot] = 1'b0;
                    pos = (pos + 1) % scvs_pkg::POOL_ENTRIES;
                end
            end
            if (!found) begin
                res.status = scvs_pkg::STATUS_NO_UNFIXED;
            end else begin
                slot          = base + pos;
                res.status    = scvs_pkg::STATUS_ALLOC;
                res.victim    = pos[scvs_pkg::VICTIM_W-1:0];
                res.flush     = dirty_q[slot];
                res.unhash    = key_q[slot];
                hand_q[r.pool] = (pos + 1) % scvs_pkg::POOL_ENTRIES;
                refer_q[slot] = 1'b1;
                dirty_q[slot] = 1'b0;
                fix_q[slot]   = '0;
                key_q[slot]   = 1'b0;
            end
        end
        awaited_results.push_back(res);
    endfunction

    function void check_result(buf_result_t got);
        buf_result_t want;
        if (awaited_results.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result: st=%0d victim=%0d flush=%0b unhash=%0b",
                         got.status, got.victim, got.flush, got.unhash);
            return;
        end
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.victim !== want.victim ||
            got.flush !== want.flush || got.unhash !== want.unhash) begin
            failures++;
            if (failures <= 10)
                $display("mismatch: want st=%0d victim=%0d flush=%0b unhash=%0b, %s%0d %s%0d %s%0b %s%0b",
                         want.status, want.victim, want.flush, want.unhash,
                         "got st=", got.status, "victim=", got.victim,
                         "flush=", got.flush, "unhash=", got.unhash);
        end
    endfunction

    function int outstanding();
        return awaited_results.size();
    endfunction
endclass

module tb_second_chance_victim_select;

    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT  = 3_000_000;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [scvs_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [scvs_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [scvs_pkg::M_TDATA_W-1:0] m_tdata;
    logic [scvs_pkg::M_TUSER_W-1:0] m_tuser;

    victim_scoreboard sb = new();

    int cycle_count = 0;
    int sent_count  = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;

    second_chance_victim_select u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: check on handshake, then pick the next ready level
    always @(posedge aclk) begin : result_sink
        buf_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = scvs_pkg::status_t'(m_tuser);
            got.victim = m_tdata[scvs_pkg::VICTIM_W-1:0];
            got.flush  = m_tdata[6];
            got.unhash = m_tdata[7];
            sb.check_result(got);
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 300);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_request(input buf_request_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(scvs_pkg::S_TDATA_W-17){1'b0}}, r.key, r.fix, r.dirty, r.refer, r.idx};
        s_tuser  <= {r.pool, r.op};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
        sent_count++;
        burst_left--;
    endtask

    task automatic update_entry(input logic pool, input int idx, input logic refer,
                                input logic dirty, input int fix, input logic key);
        buf_request_t r;
        r.op    = scvs_pkg::OP_UPDATE;
        r.pool  = pool;
        r.idx   = idx[scvs_pkg::ENTRY_INDEX_W-1:0];
        r.refer = refer;
        r.dirty = dirty;
        r.fix   = fix[scvs_pkg::FIX_VALUE_W-1:0];
        r.key   = key;
        send_request(r);
    endtask

    task automatic allocate(input logic pool);
        buf_request_t r;
        logic [31:0]  raw;
        raw     = $urandom;
        r       = raw[$bits(buf_request_t)-1:0];
        r.op    = scvs_pkg::OP_ALLOC;
        r.pool  = pool;
        send_request(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() > 0);
    endtask

    function automatic int random_fix();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0;
    endfunction

    // pin every entry, sweep for nothing, then leave one referenced entry free
    task automatic pin_pool(input logic pool);
        int spare;
        for (int i = 0; i < scvs_pkg::POOL_ENTRIES; i++)
            update_entry(pool, i, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 255),
                         1'($urandom_range(0, 1)));
        allocate(pool);
        spare = $urandom_range(0, scvs_pkg::POOL_ENTRIES - 1);
        update_entry(pool, spare, 1'b1, 1'($urandom_range(0, 1)), 0,
                     1'($urandom_range(0, 1)));
        allocate(pool);
        // victim comes back referenced: found on the very last sweep slot
        allocate(pool);
        for (int i = 0; i < scvs_pkg::POOL_ENTRIES; i++)
            update_entry(pool, i, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : 0,
                         1'($urandom_range(0, 1)));
    endtask

    // a run of referenced entries makes the next sweeps long
    task automatic warm_run(input logic pool);
        int start;
        int len;
        start = $urandom_range(0, scvs_pkg::POOL_ENTRIES - 1);
        len   = $urandom_range(1, scvs_pkg::POOL_ENTRIES);
        for (int i = 0; i < len; i++)
            update_entry(pool, (start + i) % scvs_pkg::POOL_ENTRIES, 1'b1,
                         1'($urandom_range(0, 1)),
                         ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : 0,
                         1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 4)) allocate(pool);
    endtask

    task automatic random_request();
        buf_request_t r;
        logic [31:0]  raw;
        int           fix;
        raw   = $urandom;
        r     = raw[$bits(buf_request_t)-1:0];
        fix   = random_fix();
        r.fix = fix[scvs_pkg::FIX_VALUE_W-1:0];
        send_request(r);
    endtask

    initial begin : stimulus
        int pick;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        allocate(1'b0);
        allocate(1'b1);
        update_entry(1'b0, 1, 1'b1, 1'b1, 0, 1'b1);
        update_entry(1'b0, 2, 1'b0, 1'b1, 0, 1'b1);
        allocate(1'b0);
        update_entry(1'b0, 3, 1'b0, 1'b0, 255, 1'b1);
        update_entry(1'b0, 4, 1'b0, 1'b1, 0, 1'b0);
        allocate(1'b0);
        update_entry(1'b1, 63, 1'b1, 1'b1, 1, 1'b1);
        update_entry(1'b1, 42, 1'b1, 1'b0, 8'h55, 1'b0);
        update_entry(1'b1, 21, 1'b0, 1'b1, 8'hAA, 1'b1);
        update_entry(1'b1, 1, 1'b1, 1'b0, 0, 1'b1);
        allocate(1'b1);
        allocate(1'b1);
        update_entry(1'b0, 5, 1'b0, 1'b0, 0, 1'b1);
        allocate(1'b0);
        drain();

        pin_pool(1'b1);
        while (sent_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 999);
            if (pick < 3) begin
                drain();
                pin_pool(1'($urandom_range(0, 1)));
            end else if (pick < 43) begin
                warm_run(1'($urandom_range(0, 1)));
            end else if (pick < 53) begin
                drain();
            end else begin
                random_request();
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== second_chance_victim_select.f =====
rtl/scvs_pkg.sv
rtl/scvs_ctrl.sv
rtl/scvs_datapath.sv
rtl/second_chance_victim_select.sv
dv/tb_second_chance_victim_select.sv
